### design/xxh_pkg.sv
package xxh_pkg;

	localparam logic [63:0] P1 = 64'h9e3779b185ebca87;
	localparam logic [63:0] P2 = 64'hc2b2ae3d27d4eb4f;
	localparam logic [63:0] P3 = 64'h165667b19e3779f9;
	localparam logic [63:0] P4 = 64'h85ebca77c2b2ae63;
	localparam logic [63:0] P5 = 64'h27d4eb2f165667c5;

	// datapath operations, one per sequencer step
	typedef enum logic [4:0] {
		OP_NONE,
		OP_ABSORB,     // store word / length update
		OP_RND_MUL1,   // t = x * P2
		OP_RND_MUL2,   // t = rotl(acc + t,31) * P1 -> lane
		OP_CONV_INIT,  // h = sum of rotated lanes, or seed + P5
		OP_MRG_MUL1,   // t = lane * P2
		OP_MRG_MUL2,   // t = rotl(t,31) * P1
		OP_MRG_MUL3,   // t = (h ^ t) * P1
		OP_MRG_ADD,    // h = t + P4
		OP_ADD_LEN,    // h += len
		OP_PW_MUL1,
		OP_PW_MUL2,
		OP_PW_MUL3,    // t = rotl(h ^ t,27) * P1
		OP_PW_ADD,
		OP_W4_MUL1,    // t = lo32 * P1
		OP_W4_MUL2,    // t = rotl(h ^ t,23) * P2
		OP_W4_ADD,     // h = t + P3
		OP_B_MUL1,     // word = byte * P5
		OP_B_MUL2,     // h = rotl(h ^ word,11) * P1
		OP_AV_MUL1,    // t = (h ^ h>>33) * P2
		OP_AV_MUL2,    // t = (t ^ t>>29) * P3
		OP_AV_OUT,     // h = t ^ t>>32
		OP_CLEAR
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
		logic       wr;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] pend_cnt;
		logic       stripe;
		logic [3:0] nbytes;
		logic       full_stripe;
	} dp_stat_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		rotl = (x << r) | (x >> (64 - r));
	endfunction

endpackage

### design/xxh_datapath.sv
module xxh_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [63:0]       cfg_data,
	input  logic              in_take,
	input  logic [63:0]       in_word,
	input  logic [3:0]        in_count,
	input  logic              in_last,
	input  xxh_pkg::dp_cmd_t  cmd,
	output xxh_pkg::dp_stat_t stat,
	output logic [63:0]       hash
);

	logic [63:0] seed_q;
	logic [63:0] lane_q [4];
	logic [63:0] pend_q [3];
	logic [1:0]  pcnt_q;
	logic        stripe_q;
	logic [63:0] len_q;
	logic [63:0] word_q;
	logic [3:0]  nb_q;
	logic        full_q;
	logic [63:0] h_q;
	logic [63:0] t_q;
	logic [3:0]  nb_in;
	logic [63:0] sel_word;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic [63:0] mul_ll_s1;
	logic [31:0] mul_lh_s1;
	logic [31:0] mul_hl_s1;
	logic [63:0] prod;

	assign nb_in = (in_last && in_count < 4'd8) ? in_count : 4'd8;
	assign sel_word = (cmd.idx == 2'd3) ? word_q : pend_q[cmd.idx];

	always_comb begin
		mul_a = '0;
		mul_b = xxh_pkg::P1;
		case (cmd.op)
			xxh_pkg::OP_RND_MUL1: begin
				mul_a = sel_word;
				mul_b = xxh_pkg::P2;
			end
			xxh_pkg::OP_RND_MUL2: mul_a = xxh_pkg::rotl(lane_q[cmd.idx] + t_q, 31);
			xxh_pkg::OP_MRG_MUL1: begin
				mul_a = lane_q[cmd.idx];
				mul_b = xxh_pkg::P2;
			end
			xxh_pkg::OP_MRG_MUL2, xxh_pkg::OP_PW_MUL2: mul_a = xxh_pkg::rotl(t_q, 31);
			xxh_pkg::OP_MRG_MUL3: mul_a = h_q ^ t_q;
			xxh_pkg::OP_PW_MUL1: begin
				mul_a = pend_q[cmd.idx];
				mul_b = xxh_pkg::P2;
			end
			xxh_pkg::OP_PW_MUL3: mul_a = xxh_pkg::rotl(h_q ^ t_q, 27);
			xxh_pkg::OP_W4_MUL1: mul_a = {32'd0, word_q[31:0]};
			xxh_pkg::OP_W4_MUL2: begin
				mul_a = xxh_pkg::rotl(h_q ^ t_q, 23);
				mul_b = xxh_pkg::P2;
			end
			xxh_pkg::OP_B_MUL1: begin
				mul_a = {56'd0, t_q[7:0]};
				mul_b = xxh_pkg::P5;
			end
			xxh_pkg::OP_B_MUL2: mul_a = xxh_pkg::rotl(h_q ^ word_q, 11);
			xxh_pkg::OP_AV_MUL1: begin
				mul_a = h_q ^ (h_q >> 33);
				mul_b = xxh_pkg::P2;
			end
			xxh_pkg::OP_AV_MUL2: begin
				mul_a = t_q ^ (t_q >> 29);
				mul_b = xxh_pkg::P3;
			end
			default: ;
		endcase
	end

	// low 64 bits of the product from three 32x32 partials; operands are held
	// across the multiply step and the sum of the registered partials is used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_ll_s1 <= '0;
			mul_lh_s1 <= '0;
			mul_hl_s1 <= '0;
		end else begin
			mul_ll_s1 <= mul_a[31:0] * mul_b[31:0];
			mul_lh_s1 <= mul_a[31:0] * mul_b[63:32];
			mul_hl_s1 <= mul_a[63:32] * mul_b[31:0];
		end
	end

	assign prod = mul_ll_s1 + {mul_lh_s1 + mul_hl_s1, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			lane_q[0] <= xxh_pkg::P1 + xxh_pkg::P2;
			lane_q[1] <= xxh_pkg::P2;
			lane_q[2] <= '0;
			lane_q[3] <= -xxh_pkg::P1;
			pcnt_q   <= '0;
			stripe_q <= 1'b0;
			len_q    <= '0;
			word_q   <= '0;
			nb_q     <= '0;
			full_q   <= 1'b0;
			h_q      <= '0;
			t_q      <= '0;
		end else if (cfg_we) begin
			seed_q    <= cfg_data;
			lane_q[0] <= cfg_data + xxh_pkg::P1 + xxh_pkg::P2;
			lane_q[1] <= cfg_data + xxh_pkg::P2;
			lane_q[2] <= cfg_data;
			lane_q[3] <= cfg_data - xxh_pkg::P1;
		end else begin
			if (in_take) begin
				word_q <= in_word & ((nb_in == 4'd8) ? '1 :
					~({64{1'b1}} << {nb_in[2:0], 3'b000}));
				nb_q   <= nb_in;
				len_q  <= len_q + 64'(nb_in);
				full_q <= (nb_in == 4'd8) && (pcnt_q == 2'd3);
				if (nb_in == 4'd8 && pcnt_q != 2'd3) begin
					pend_q[pcnt_q] <= in_word;
					pcnt_q <= pcnt_q + 2'd1;
				end
			end
			if (cmd.wr) begin
				case (cmd.op)
					xxh_pkg::OP_RND_MUL1: t_q <= prod;
					xxh_pkg::OP_RND_MUL2: begin
						lane_q[cmd.idx] <= prod;
						if (cmd.idx == 2'd3) begin
							pcnt_q   <= '0;
							stripe_q <= 1'b1;
							full_q   <= 1'b0;
						end
					end
					xxh_pkg::OP_CONV_INIT: h_q <= stripe_q ?
						xxh_pkg::rotl(lane_q[0], 1) + xxh_pkg::rotl(lane_q[1], 7) +
						xxh_pkg::rotl(lane_q[2], 12) + xxh_pkg::rotl(lane_q[3], 18) :
						seed_q + xxh_pkg::P5;
					xxh_pkg::OP_MRG_MUL1, xxh_pkg::OP_MRG_MUL2, xxh_pkg::OP_MRG_MUL3,
					xxh_pkg::OP_PW_MUL1, xxh_pkg::OP_PW_MUL2, xxh_pkg::OP_PW_MUL3,
					xxh_pkg::OP_W4_MUL1, xxh_pkg::OP_W4_MUL2,
					xxh_pkg::OP_AV_MUL1, xxh_pkg::OP_AV_MUL2: t_q <= prod;
					xxh_pkg::OP_MRG_ADD: h_q <= t_q + xxh_pkg::P4;
					// byte loop start: W4 step leaves upper half in t_q; without it,
					// whole word loaded here
					xxh_pkg::OP_PW_ADD: begin
						h_q <= t_q + xxh_pkg::P4;
						t_q <= word_q;
					end
					xxh_pkg::OP_ADD_LEN: begin
						h_q <= h_q + len_q;
						t_q <= word_q;
					end
					xxh_pkg::OP_W4_ADD: begin
						h_q <= t_q + xxh_pkg::P3;
						t_q <= word_q >> 32;
					end
					xxh_pkg::OP_B_MUL1: begin
						// byte product parked in word_q; t_q shifts to next byte
						word_q <= prod;
						t_q    <= t_q >> 8;
					end
					xxh_pkg::OP_B_MUL2: h_q <= prod;
					xxh_pkg::OP_AV_OUT: h_q <= t_q ^ (t_q >> 32);
					xxh_pkg::OP_CLEAR: begin
						lane_q[0] <= seed_q + xxh_pkg::P1 + xxh_pkg::P2;
						lane_q[1] <= seed_q + xxh_pkg::P2;
						lane_q[2] <= seed_q;
						lane_q[3] <= seed_q - xxh_pkg::P1;
						pcnt_q   <= '0;
						stripe_q <= 1'b0;
						len_q    <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign stat.pend_cnt    = pcnt_q;
	assign stat.stripe      = stripe_q;
	assign stat.nbytes      = nb_q;
	assign stat.full_stripe = full_q;
	assign hash = h_q;

endmodule

### design/xxh_ctrl.sv
module xxh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_take,
	output logic              out_valid,
	input  logic              out_stall,
	input  xxh_pkg::dp_stat_t stat,
	output xxh_pkg::dp_cmd_t  cmd
);

	xxh_pkg::state_t state_q, state_d;
	xxh_pkg::dp_op_t op_q, op_d;
	logic [1:0] idx_q, idx_d;
	logic [3:0] cnt_q, cnt_d;     // bytes left in the byte loop
	logic       last_q, last_d;
	logic       ph_q, ph_d;       // second phase of a multiply step
	logic       mul_op;

	assign mul_op = op_q inside {xxh_pkg::OP_RND_MUL1, xxh_pkg::OP_RND_MUL2,
		xxh_pkg::OP_MRG_MUL1, xxh_pkg::OP_MRG_MUL2, xxh_pkg::OP_MRG_MUL3,
		xxh_pkg::OP_PW_MUL1, xxh_pkg::OP_PW_MUL2, xxh_pkg::OP_PW_MUL3,
		xxh_pkg::OP_W4_MUL1, xxh_pkg::OP_W4_MUL2,
		xxh_pkg::OP_B_MUL1, xxh_pkg::OP_B_MUL2,
		xxh_pkg::OP_AV_MUL1, xxh_pkg::OP_AV_MUL2};

	assign in_take   = (state_q == xxh_pkg::ST_IDLE) && in_valid;
	assign out_valid = (state_q == xxh_pkg::ST_OUT);
	assign cmd.op    = (state_q == xxh_pkg::ST_RUN) ? op_q : xxh_pkg::OP_NONE;
	assign cmd.idx   = idx_q;
	assign cmd.wr    = (state_q == xxh_pkg::ST_RUN) && !(mul_op && !ph_q);

	// next op after op_q finishes
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		last_d  = last_q;
		ph_d    = 1'b0;
		unique case (state_q)
			xxh_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = xxh_pkg::ST_RUN;
					op_d    = xxh_pkg::OP_ABSORB;
					last_d  = in_last;
				end
			end
			xxh_pkg::ST_RUN: begin
				if (mul_op && !ph_q) begin
					ph_d = 1'b1;
				end else begin
					unique case (op_q)
						xxh_pkg::OP_ABSORB: begin
							idx_d = '0;
							if (stat.full_stripe) op_d = xxh_pkg::OP_RND_MUL1;
							else if (last_q) op_d = xxh_pkg::OP_CONV_INIT;
							else state_d = xxh_pkg::ST_IDLE;
						end
						xxh_pkg::OP_RND_MUL1: op_d = xxh_pkg::OP_RND_MUL2;
						xxh_pkg::OP_RND_MUL2: begin
							idx_d = idx_q + 2'd1;
							if (idx_q != 2'd3) op_d = xxh_pkg::OP_RND_MUL1;
							else if (last_q) op_d = xxh_pkg::OP_CONV_INIT;
							else state_d = xxh_pkg::ST_IDLE;
						end
						xxh_pkg::OP_CONV_INIT: begin
							idx_d = '0;
							op_d = stat.stripe ? xxh_pkg::OP_MRG_MUL1 : xxh_pkg::OP_ADD_LEN;
						end
						xxh_pkg::OP_MRG_MUL1: op_d = xxh_pkg::OP_MRG_MUL2;
						xxh_pkg::OP_MRG_MUL2: op_d = xxh_pkg::OP_MRG_MUL3;
						xxh_pkg::OP_MRG_MUL3: op_d = xxh_pkg::OP_MRG_ADD;
						xxh_pkg::OP_MRG_ADD: begin
							idx_d = idx_q + 2'd1;
							op_d = (idx_q == 2'd3) ? xxh_pkg::OP_ADD_LEN :
								xxh_pkg::OP_MRG_MUL1;
						end
						xxh_pkg::OP_ADD_LEN, xxh_pkg::OP_PW_ADD: begin
							if (op_q == xxh_pkg::OP_PW_ADD) idx_d = idx_q + 2'd1;
							else idx_d = '0;
							if ((op_q == xxh_pkg::OP_PW_ADD ? idx_q + 2'd1 : 2'd0) <
								stat.pend_cnt)
								op_d = xxh_pkg::OP_PW_MUL1;
							else if (stat.nbytes >= 4'd4 && stat.nbytes < 4'd8) begin
								op_d = xxh_pkg::OP_W4_MUL1;
							end else if (stat.nbytes < 4'd4) begin
								cnt_d = stat.nbytes;
								op_d = (stat.nbytes == 4'd0) ? xxh_pkg::OP_AV_MUL1 :
									xxh_pkg::OP_B_MUL1;
							end else op_d = xxh_pkg::OP_AV_MUL1;
						end
						xxh_pkg::OP_PW_MUL1: op_d = xxh_pkg::OP_PW_MUL2;
						xxh_pkg::OP_PW_MUL2: op_d = xxh_pkg::OP_PW_MUL3;
						xxh_pkg::OP_PW_MUL3: op_d = xxh_pkg::OP_PW_ADD;
						xxh_pkg::OP_W4_MUL1: op_d = xxh_pkg::OP_W4_MUL2;
						xxh_pkg::OP_W4_MUL2: op_d = xxh_pkg::OP_W4_ADD;
						xxh_pkg::OP_W4_ADD: begin
							cnt_d = stat.nbytes - 4'd4;
							op_d = (cnt_d == 4'd0) ? xxh_pkg::OP_AV_MUL1 :
								xxh_pkg::OP_B_MUL1;
						end
						xxh_pkg::OP_B_MUL1: op_d = xxh_pkg::OP_B_MUL2;
						xxh_pkg::OP_B_MUL2: begin
							cnt_d = cnt_q - 4'd1;
							op_d = (cnt_q == 4'd1) ? xxh_pkg::OP_AV_MUL1 :
								xxh_pkg::OP_B_MUL1;
						end
						xxh_pkg::OP_AV_MUL1: op_d = xxh_pkg::OP_AV_MUL2;
						xxh_pkg::OP_AV_MUL2: op_d = xxh_pkg::OP_AV_OUT;
						xxh_pkg::OP_AV_OUT: op_d = xxh_pkg::OP_CLEAR;
						xxh_pkg::OP_CLEAR: state_d = xxh_pkg::ST_OUT;
						default: state_d = xxh_pkg::ST_IDLE;
					endcase
				end
			end
			xxh_pkg::ST_OUT: if (!out_stall) state_d = xxh_pkg::ST_IDLE;
			default: state_d = xxh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xxh_pkg::ST_IDLE;
			op_q    <= xxh_pkg::OP_NONE;
			idx_q   <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
			ph_q    <= ph_d;
		end
	end

endmodule

### design/xxh64_stream_hash.sv
// channel | signals                                    | direction
// input   | in_valid, in_stall, data_word, byte_count, last | into block
// output  | out_valid, out_stall, hash_value           | out of block
// config  | seed_we, seed_value                        | into block
// A word that closes a stripe adds four lane rounds, each multiply
// on the shared multiplier. A final word adds the merge (with
// stripes), a step per pending word, the 4-byte step, a step per
// byte and the avalanche. Reset clears seed and counts and loads
// the lanes for a zero seed. in_stall is high whenever the block is
// busy or holds a result; out_stall holds the result in place.
module xxh64_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value,
	input  logic        seed_we,
	input  logic [63:0] seed_value
);

	xxh_pkg::dp_cmd_t  cmd;
	xxh_pkg::dp_stat_t stat;
	logic take;

	xxh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(last),
		.in_take(take), .out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	xxh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(seed_we), .cfg_data(seed_value),
		.in_take(take), .in_word(data_word), .in_count(byte_count), .in_last(last),
		.cmd(cmd), .stat(stat), .hash(hash_value)
	);

	assign in_stall = !take;

endmodule

### design/xxh_checker.sv
module xxh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] hash_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value))
		else $error("result dropped while stalled");

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_out_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");

	a_idle_input_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid |-> in_stall)
		else $error("input ready without a transfer offered");

endmodule

bind xxh64_stream_hash xxh_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .hash_value(hash_value)
);

### tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [63:0] data_word = '0;
	logic [3:0]  byte_count = '0;
	logic        last = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [63:0] hash_value;
	logic        seed_we = 0;
	logic [63:0] seed_value = '0;

	xxh64_stream_hash dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_word(data_word), .byte_count(byte_count), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .hash_value(hash_value),
		.seed_we(seed_we), .seed_value(seed_value)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [63:0] m_seed;
	logic [63:0] m_lane [4];
	logic [63:0] m_pend [3];
	int          m_npend;
	bit          m_stripe;
	logic [63:0] m_len;
	logic [63:0] hash_q [$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_req = 0;
	bit  hold_off = 0;
	int  errors = 0;
	longint cycles = 0;

	function automatic logic [63:0] rol(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] lane_round(logic [63:0] acc, logic [63:0] w);
		return rol(acc + w * xxh_pkg::P2, 31) * xxh_pkg::P1;
	endfunction

	function automatic void reload_lanes();
		m_lane[0] = m_seed + xxh_pkg::P1 + xxh_pkg::P2;
		m_lane[1] = m_seed + xxh_pkg::P2;
		m_lane[2] = m_seed;
		m_lane[3] = m_seed - xxh_pkg::P1;
		m_npend = 0;
		m_stripe = 0;
		m_len = 0;
	endfunction

	function automatic void absorb_word(logic [63:0] w, logic [3:0] bc, bit fin);
		int n;
		int off;
		logic [63:0] h;
		n = (fin && bc < 8) ? bc : 8;
		off = 0;
		m_len += 64'(n);
		if (n == 8) begin
			if (m_npend < 3) begin
				m_pend[m_npend] = w;
				m_npend++;
			end else begin
				for (int i = 0; i < 3; i++) m_lane[i] = lane_round(m_lane[i], m_pend[i]);
				m_lane[3] = lane_round(m_lane[3], w);
				m_npend = 0;
				m_stripe = 1;
			end
		end
		if (!fin)
			return;
		if (m_stripe) begin
			h = rol(m_lane[0], 1) + rol(m_lane[1], 7) + rol(m_lane[2], 12) +
				rol(m_lane[3], 18);
			for (int i = 0; i < 4; i++)
				h = ((h ^ lane_round(0, m_lane[i])) * xxh_pkg::P1) + xxh_pkg::P4;
		end else
			h = m_seed + xxh_pkg::P5;
		h += m_len;
		for (int i = 0; i < m_npend; i++)
			h = rol(h ^ lane_round(0, m_pend[i]), 27) * xxh_pkg::P1 + xxh_pkg::P4;
		if (n < 8) begin
			if (n >= 4) begin
				h ^= {32'b0, w[31:0]} * xxh_pkg::P1;
				h = rol(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
				off = 4;
			end
			for (int i = off; i < n; i++) begin
				h ^= {56'b0, w[8*i +: 8]} * xxh_pkg::P5;
				h = rol(h, 11) * xxh_pkg::P1;
			end
		end
		h ^= h >> 33;
		h *= xxh_pkg::P2;
		h ^= h >> 29;
		h *= xxh_pkg::P3;
		h ^= h >> 32;
		hash_q.push_back(h);
		reload_lanes();
	endfunction

	// one transfer on the input channel
	task automatic send_word(logic [63:0] w, logic [3:0] bc, bit fin);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1;
		data_word <= w;
		byte_count <= bc;
		last <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		absorb_word(w, bc, fin);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_message(int nwords, logic [3:0] bc);
		for (int i = 0; i < nwords - 1; i++)
			send_word({$urandom, $urandom}, 4'($urandom_range(15)), 0);
		send_word({$urandom, $urandom}, bc, 1);
	endtask

	task automatic drain();
		while (hash_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] s);
		drain();
		seed_we <= 1;
		seed_value <= s;
		@(posedge clk);
		seed_we <= 0;
		m_seed = s;
		reload_lanes();
	endtask

	task automatic test_directed();
		send_word(64'hffff_ffff_ffff_ffff, 0, 1);
		send_word(64'h0, 8, 1);
		send_word(64'hffff_ffff_ffff_ffff, 15, 1);
		send_word(64'h0123_4567_89ab_cdef, 4, 1);
		send_word(64'hfedc_ba98_7654_3210, 7, 1);
		send_word(64'hffff_ffff_ffff_ffff, 1, 1);
		for (int i = 0; i < 4; i++) send_word(64'hffff_ffff_ffff_ffff, 8, 0);
		send_word(64'h0, 0, 1);
		for (int i = 0; i < 7; i++) send_word({$urandom, $urandom}, 3, 0);
		send_word(64'haaaa_5555_aaaa_5555, 5, 1);
	endtask

	task automatic test_seeds();
		write_seed(64'hffff_ffff_ffff_ffff);
		send_message(5, 6);
		send_message(1, 2);
		write_seed(64'h0);
		send_message(4, 8);
		write_seed({$urandom, $urandom});
		send_message(9, 3);
	endtask

	task automatic test_random(int nitems);
		int sent;
		int len;
		sent = 0;
		while (sent < nitems) begin
			len = $urandom_range(99) < 70 ? $urandom_range(1, 6) : $urandom_range(7, 20);
			send_message(len,
				4'($urandom_range(99) < 85 ? $urandom_range(8) : $urandom_range(15)));
			sent += len;
		end
	endtask

	task automatic test_backpressure();
		hold_req <= 1;
		send_message(12, 5);
		send_message(3, 8);
		hold_req <= 0;
	endtask

	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1;
		else if (recv_idle_pct > 0)
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		else
			out_stall <= 0;
	end

	// long receiver hold-off, counted here
	int stall_run = 0;
	always @(posedge clk) begin
		if (hold_req && stall_run < 300) begin
			hold_off <= 1;
			stall_run <= stall_run + 1;
		end else
			hold_off <= 0;
		if (!hold_req)
			stall_run <= 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (hash_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected hash %h", hash_value);
			end else begin
				if (hash_value !== hash_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("hash mismatch: exp %h got %h", hash_q[0], hash_value);
				end
				void'(hash_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		m_seed = 0;
		reload_lanes();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_seeds();
		write_seed(64'h1234);
		send_idle_pct = 8;
		recv_idle_pct = 66;
		test_random(150);
		test_backpressure();
		send_idle_pct = 66;
		recv_idle_pct = 8;
		test_random(130);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(130);
		drain();
		if (errors == 0 && hash_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

### filelist.f
design/xxh_pkg.sv
design/xxh_datapath.sv
design/xxh_ctrl.sv
design/xxh64_stream_hash.sv
design/xxh_checker.sv
tb/sv/tb.sv
